FILE: design/imm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the integer matrix multiply core.
// No dependencies; every other file of the block refers to this package.
package imm_pkg;

	// Fixed field widths of the item, result and configuration channels.
	localparam int ACTION_W    = 2;
	localparam int INDEX_W     = 8;
	localparam int VALUE_W     = 32;
	localparam int POS_W       = 5;
	localparam int ROWS_W      = 6;
	localparam int INNER_W     = 9;
	localparam int COLS_W      = 6;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 9;

	// Reset values of the size registers.
	localparam logic [ROWS_W-1:0]  ROWS_RESET  = 6'd32;
	localparam logic [INNER_W-1:0] INNER_RESET = 9'd256;
	localparam logic [COLS_W-1:0]  COLS_RESET  = 6'd32;

	// Item action codes.
	localparam logic [ACTION_W-1:0] ACT_LOAD_A  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_LOAD_B  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_COMPUTE = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_ROWS  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_INNER = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_COLS  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic start;
		logic issue;
		logic finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_bad;
		logic inner_zero;
		logic last;
		logic busy;
		logic out_free;
	} sts_t;

endpackage

FILE: design/imm_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the integer matrix multiply core: input items,
// result items and configuration writes. Depends on imm_pkg for widths.

interface imm_item_if;
	logic                                valid;
	logic                                ready;
	logic [imm_pkg::ACTION_W-1:0]        action;
	logic [imm_pkg::INDEX_W-1:0]         row_index;
	logic [imm_pkg::INDEX_W-1:0]         col_index;
	logic signed [imm_pkg::VALUE_W-1:0]  element_value;

	modport source (output valid, action, row_index, col_index, element_value, input ready);
	modport sink (input valid, action, row_index, col_index, element_value, output ready);
endinterface

interface imm_result_if;
	logic                                valid;
	logic                                ready;
	logic signed [imm_pkg::VALUE_W-1:0]  product_value;
	logic [imm_pkg::POS_W-1:0]           product_row;
	logic [imm_pkg::POS_W-1:0]           product_col;
	logic                                bad_index;

	modport source (output valid, product_value, product_row, product_col, bad_index,
		input ready);
	modport sink (input valid, product_value, product_row, product_col, bad_index,
		output ready);
endinterface

interface imm_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [imm_pkg::CFG_INDEX_W-1:0]    index;
	logic [imm_pkg::CFG_DATA_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: design/imm_ctrl.sv
`timescale 1ns / 1ps
// Controller of the integer matrix multiply core: accepts items and
// sequences a compute through the datapath. Depends on imm_pkg.
module imm_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [imm_pkg::ACTION_W-1:0]  in_action,
	output logic                          in_ready,
	input  imm_pkg::sts_t                 sts,
	output imm_pkg::cmd_t                 cmd
);

	imm_pkg::state_t state_q, state_next;
	logic            accept;

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= imm_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			imm_pkg::ST_IDLE: begin
				if (accept && in_action == imm_pkg::ACT_COMPUTE) begin
					// Out-of-range positions and an empty inner size skip the walk.
					if (sts.in_bad || sts.inner_zero) begin
						state_next = imm_pkg::ST_FINISH;
					end else begin
						state_next = imm_pkg::ST_RUN;
					end
				end
			end
			imm_pkg::ST_RUN: begin
				if (sts.last) begin
					state_next = imm_pkg::ST_DRAIN;
				end
			end
			imm_pkg::ST_DRAIN: begin
				if (!sts.busy) begin
					state_next = imm_pkg::ST_FINISH;
				end
			end
			imm_pkg::ST_FINISH: begin
				if (sts.out_free) begin
					state_next = imm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = imm_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd.load   = 1'b0;
		cmd.start  = 1'b0;
		cmd.issue  = 1'b0;
		cmd.finish = 1'b0;
		case (state_q)
			imm_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.load  = in_valid && (in_action inside {imm_pkg::ACT_LOAD_A,
					imm_pkg::ACT_LOAD_B});
				cmd.start = in_valid && in_action == imm_pkg::ACT_COMPUTE;
			end
			imm_pkg::ST_RUN: begin
				cmd.issue = 1'b1;
			end
			imm_pkg::ST_DRAIN: begin
			end
			imm_pkg::ST_FINISH: begin
				cmd.finish = sts.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: design/imm_datapath.sv
`timescale 1ns / 1ps
// Datapath of the integer matrix multiply core: size registers, the two
// matrix memories, the multiply-accumulate pipeline and the result register.
// Depends on imm_pkg and imm_if.
module imm_datapath #(
	parameter int MAX_ROWS  = 32,
	parameter int MAX_INNER = 256,
	parameter int MAX_COLS  = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [imm_pkg::ACTION_W-1:0]        in_action,
	input  logic [imm_pkg::INDEX_W-1:0]         in_row,
	input  logic [imm_pkg::INDEX_W-1:0]         in_col,
	input  logic signed [imm_pkg::VALUE_W-1:0]  in_value,
	input  imm_pkg::cmd_t                       cmd,
	output imm_pkg::sts_t                       sts,
	imm_cfg_if.sink                             cfg,
	imm_result_if.source                        result
);

	localparam int RSW   = $clog2(MAX_ROWS + 1);
	localparam int KSW   = $clog2(MAX_INNER + 1);
	localparam int CSW   = $clog2(MAX_COLS + 1);
	localparam int KW    = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
	localparam int A_DEP = MAX_ROWS * MAX_INNER;
	localparam int B_DEP = MAX_INNER * MAX_COLS;
	localparam int A_AW  = (A_DEP > 1) ? $clog2(A_DEP) : 1;
	localparam int B_AW  = (B_DEP > 1) ? $clog2(B_DEP) : 1;

	logic [imm_pkg::ROWS_W-1:0]   rows_q;
	logic [imm_pkg::INNER_W-1:0]  inner_q;
	logic [imm_pkg::COLS_W-1:0]   cols_q;
	logic [RSW-1:0]               nr;
	logic [KSW-1:0]               nk;
	logic [CSW-1:0]               nc;

	logic [imm_pkg::VALUE_W-1:0]  mem_a [A_DEP];
	logic [imm_pkg::VALUE_W-1:0]  mem_b [B_DEP];
	logic [A_AW-1:0]              a_waddr, a_raddr;
	logic [B_AW-1:0]              b_waddr, b_raddr;
	logic                         a_wr, b_wr;

	logic [imm_pkg::INDEX_W-1:0]  row_q, col_q;
	logic                         bad_q;
	logic [KW-1:0]                k_q;
	logic                         valid_s1, valid_s2;
	logic [imm_pkg::VALUE_W-1:0]  a_rd_s1, b_rd_s1, prod_s2, acc_q;

	logic                               out_valid_q;
	logic signed [imm_pkg::VALUE_W-1:0] out_value_q;
	logic [imm_pkg::POS_W-1:0]          out_row_q, out_col_q;
	logic                               out_bad_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= imm_pkg::ROWS_RESET;
			inner_q <= imm_pkg::INNER_RESET;
			cols_q  <= imm_pkg::COLS_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				imm_pkg::REG_ROWS:  rows_q  <= cfg.data[imm_pkg::ROWS_W-1:0];
				imm_pkg::REG_INNER: inner_q <= cfg.data[imm_pkg::INNER_W-1:0];
				imm_pkg::REG_COLS:  cols_q  <= cfg.data[imm_pkg::COLS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sizes in effect saturate at the build-time maximums.
	assign nr = (rows_q > MAX_ROWS) ? RSW'(MAX_ROWS) : RSW'(rows_q);
	assign nk = (inner_q > MAX_INNER) ? KSW'(MAX_INNER) : KSW'(inner_q);
	assign nc = (cols_q > MAX_COLS) ? CSW'(MAX_COLS) : CSW'(cols_q);

	assign a_wr = cmd.load && in_action == imm_pkg::ACT_LOAD_A && in_row < nr && in_col < nk;
	assign b_wr = cmd.load && in_action == imm_pkg::ACT_LOAD_B && in_row < nk && in_col < nc;

	assign a_waddr = A_AW'(in_row * MAX_INNER + in_col);
	assign b_waddr = B_AW'(in_row * MAX_COLS + in_col);
	assign a_raddr = A_AW'(row_q * MAX_INNER + k_q);
	assign b_raddr = B_AW'(k_q * MAX_COLS + col_q);

	always_ff @(posedge clk) begin
		if (a_wr) begin
			mem_a[a_waddr] <= in_value;
		end
		a_rd_s1 <= mem_a[a_raddr];
	end

	always_ff @(posedge clk) begin
		if (b_wr) begin
			mem_b[b_waddr] <= in_value;
		end
		b_rd_s1 <= mem_b[b_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			row_q <= in_row;
			col_q <= in_col;
			bad_q <= sts.in_bad;
		end
		// Only the low word of the product matters for a wrapped sum.
		prod_s2 <= a_rd_s1 * b_rd_s1;
		if (cmd.start) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= acc_q + prod_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q      <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cmd.start) begin
				k_q <= '0;
			end else if (cmd.issue) begin
				k_q <= k_q + KW'(1);
			end
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_value_q <= acc_q;
			out_row_q   <= row_q[imm_pkg::POS_W-1:0];
			out_col_q   <= col_q[imm_pkg::POS_W-1:0];
			out_bad_q   <= bad_q;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.product_value = out_value_q;
	assign result.product_row   = out_row_q;
	assign result.product_col   = out_col_q;
	assign result.bad_index     = out_bad_q;

	assign sts.in_bad     = !(in_row < nr && in_col < nc);
	assign sts.inner_zero = (nk == '0);
	assign sts.last       = (KSW'(k_q) == nk - KSW'(1));
	assign sts.busy       = valid_s1 || valid_s2;
	assign sts.out_free   = !out_valid_q || result.ready;

endmodule

FILE: design/integer_matrix_multiply_core.sv
`timescale 1ns / 1ps
// Top level of the integer matrix multiply core: controller plus datapath.
// Depends on imm_pkg, imm_if, imm_ctrl and imm_datapath.

// A load item (action 0 or 1) writes one element of A or B, so loads stream
// at one item per clock while no compute is in progress. A compute item (action 2)
// walks the inner dimension with the single 32x32 multiply-accumulate unit,
// one term per cycle, reading one word of each matrix memory per cycle,
// through memory read, multiply and accumulate stages plus hand-off to the
// result register. A position out of range or a zero inner size skips the
// walk and goes straight to the hand-off. No further item is taken during a
// compute. A finished result sits in an output register, so load items keep
// flowing while it waits to be taken. Elements never loaded read back as
// undefined values.
module integer_matrix_multiply_core #(
	parameter int MAX_ROWS  = 32,
	parameter int MAX_INNER = 256,
	parameter int MAX_COLS  = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	imm_item_if.sink      item,
	imm_result_if.source  result,
	imm_cfg_if.sink       cfg
);

	imm_pkg::cmd_t cmd;
	imm_pkg::sts_t sts;
	logic          in_ready;

	assign item.ready = in_ready;

	imm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_action (item.action),
		.in_ready  (in_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	imm_datapath #(
		.MAX_ROWS  (MAX_ROWS),
		.MAX_INNER (MAX_INNER),
		.MAX_COLS  (MAX_COLS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_action (item.action),
		.in_row    (item.row_index),
		.in_col    (item.col_index),
		.in_value  (item.element_value),
		.cmd       (cmd),
		.sts       (sts),
		.cfg       (cfg),
		.result    (result)
	);

endmodule

FILE: design/imm_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the integer matrix multiply core, bound to its top.
// Depends on imm_pkg and integer_matrix_multiply_core.
module imm_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic [imm_pkg::ACTION_W-1:0]        in_action,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [imm_pkg::VALUE_W-1:0]  out_value,
	input logic                                out_bad
);

	// A result held back by the sink stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_value) && $stable(out_bad))
		else $error("result item changed while stalled");

	// An out-of-range position always reports a zero value.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_bad |-> out_value == '0)
		else $error("flagged result item carries a nonzero value");

	// A compute item closes the input in the cycle after it is taken.
	a_compute_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_action == imm_pkg::ACT_COMPUTE |=> !in_ready)
		else $error("input taken right after a compute item");

	// A new result appears only at the end of a compute, when input is closed.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result item appeared without a compute");

endmodule

bind integer_matrix_multiply_core imm_checker u_imm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.in_action (item.action),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_value (result.product_value),
	.out_bad   (result.bad_index)
);

FILE: sim/imm_dot_product_check.sv
`timescale 1ns / 1ps
// Result checker for the integer matrix multiply core. It mirrors the size registers
// and both matrices, predicts each dot product and compares it with the result channel.
// Depends on imm_pkg and the channel interfaces in imm_if.
module imm_dot_product_check #(
	parameter int MAX_ROWS  = 32,
	parameter int MAX_INNER = 256,
	parameter int MAX_COLS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	imm_item_if         item,
	imm_result_if       result,
	imm_cfg_if          cfg,
	output int unsigned mismatches,
	output int unsigned outstanding
);

	typedef struct packed {
		logic signed [imm_pkg::VALUE_W-1:0] value;
		logic [imm_pkg::POS_W-1:0]          row;
		logic [imm_pkg::POS_W-1:0]          col;
		logic                               bad;
	} dot_t;

	dot_t                        dot_due_q[$];
	logic [imm_pkg::VALUE_W-1:0] a_words [MAX_ROWS*MAX_INNER];
	logic [imm_pkg::VALUE_W-1:0] b_words [MAX_INNER*MAX_COLS];
	logic [imm_pkg::ROWS_W-1:0]  rows_reg;
	logic [imm_pkg::INNER_W-1:0] inner_reg;
	logic [imm_pkg::COLS_W-1:0]  cols_reg;

	// A size register above the matrix capacity acts as the capacity.
	function automatic int unsigned in_effect(int unsigned size, int unsigned ceiling);
		return (size > ceiling) ? ceiling : size;
	endfunction

	function automatic dot_t predict_dot(logic [imm_pkg::INDEX_W-1:0] r,
			logic [imm_pkg::INDEX_W-1:0] c);
		dot_t                        d;
		int unsigned                 nr;
		int unsigned                 nk;
		int unsigned                 nc;
		logic [imm_pkg::VALUE_W-1:0] acc;
		nr = in_effect(rows_reg, MAX_ROWS);
		nk = in_effect(inner_reg, MAX_INNER);
		nc = in_effect(cols_reg, MAX_COLS);
		d.row = r[imm_pkg::POS_W-1:0];
		d.col = c[imm_pkg::POS_W-1:0];
		d.bad = !(r < nr && c < nc);
		acc = '0;
		if (!d.bad) begin
			// The low 32 bits of the products are the same for signed and unsigned.
			for (int unsigned k = 0; k < nk; k++)
				acc += a_words[r * MAX_INNER + k] * b_words[k * MAX_COLS + c];
		end
		d.value = acc;
		return d;
	endfunction

	task automatic flag(string what);
		$display("%0t dot product check: %s", $time, what);
		mismatches++;
	endtask

	task automatic check_field(string name, logic [imm_pkg::VALUE_W-1:0] got,
			logic [imm_pkg::VALUE_W-1:0] want);
		if (got !== want)
			flag($sformatf("%s got %0h, expected %0h", name, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		dot_t want;
		if (!arst_n) begin
			rows_reg = imm_pkg::ROWS_RESET;
			inner_reg = imm_pkg::INNER_RESET;
			cols_reg = imm_pkg::COLS_RESET;
			dot_due_q.delete();
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					imm_pkg::REG_ROWS: rows_reg = cfg.data[imm_pkg::ROWS_W-1:0];
					imm_pkg::REG_INNER: inner_reg = cfg.data[imm_pkg::INNER_W-1:0];
					imm_pkg::REG_COLS: cols_reg = cfg.data[imm_pkg::COLS_W-1:0];
					default: ;
				endcase
			end
			if (result.valid && result.ready) begin
				if (dot_due_q.size() == 0) begin
					flag($sformatf("result at row %0d col %0d with none expected",
						result.product_row, result.product_col));
				end else begin
					want = dot_due_q.pop_front();
					check_field("product_value", result.product_value, want.value);
					check_field("product_row", result.product_row, want.row);
					check_field("product_col", result.product_col, want.col);
					check_field("bad_index", result.bad_index, want.bad);
				end
			end
			if (item.valid && item.ready) begin
				case (item.action)
					imm_pkg::ACT_LOAD_A: begin
						if (item.row_index < in_effect(rows_reg, MAX_ROWS)
								&& item.col_index < in_effect(inner_reg, MAX_INNER))
							a_words[item.row_index * MAX_INNER + item.col_index] =
								item.element_value;
					end
					imm_pkg::ACT_LOAD_B: begin
						if (item.row_index < in_effect(inner_reg, MAX_INNER)
								&& item.col_index < in_effect(cols_reg, MAX_COLS))
							b_words[item.row_index * MAX_COLS + item.col_index] =
								item.element_value;
					end
					imm_pkg::ACT_COMPUTE: dot_due_q.insert(dot_due_q.size(),
						predict_dot(item.row_index, item.col_index));
					default: ;
				endcase
			end
		end
		outstanding = dot_due_q.size();
	end

endmodule

FILE: sim/integer_matrix_multiply_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for the integer matrix multiply core: clock, reset, item stimulus,
// result-side stalls and the verdict. Depends on imm_pkg, imm_if, the core and
// imm_dot_product_check.
module integer_matrix_multiply_core_tb;

	localparam int MAX_ROWS     = 32;
	localparam int MAX_INNER    = 256;
	localparam int MAX_COLS     = 32;
	localparam int QUIET_CYCLES = MAX_INNER + 8;
	localparam int HOLD_CYCLES  = 600;
	localparam int CYCLE_LIMIT  = 2000000;

	localparam logic [imm_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [imm_pkg::ACTION_W-1:0]    ACT_NONE   = 2'd3;
	localparam logic signed [imm_pkg::VALUE_W-1:0] VALUE_MAX = 32'sh7fffffff;
	localparam logic signed [imm_pkg::VALUE_W-1:0] VALUE_MIN = 32'sh80000000;

	logic        clk;
	logic        arst_n;
	int unsigned mismatches;
	int unsigned outstanding;

	imm_item_if   item_ch();
	imm_result_if result_ch();
	imm_cfg_if    cfg_ch();

	integer_matrix_multiply_core #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_INNER(MAX_INNER),
		.MAX_COLS(MAX_COLS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.cfg(cfg_ch)
	);

	imm_dot_product_check #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_INNER(MAX_INNER),
		.MAX_COLS(MAX_COLS)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.cfg(cfg_ch),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	// Size settings as the stimulus sees them, and which elements hold data.
	logic [imm_pkg::ROWS_W-1:0]  rows_set;
	logic [imm_pkg::INNER_W-1:0] inner_set;
	logic [imm_pkg::COLS_W-1:0]  cols_set;
	int unsigned        n_rows;
	int unsigned        n_inner;
	int unsigned        n_cols;
	bit                 a_loaded [MAX_ROWS*MAX_INNER];
	bit                 b_loaded [MAX_INNER*MAX_COLS];
	int unsigned        accepted;
	bit                 gapless;
	bit                 hold_armed;
	logic               long_hold;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int unsigned clamp(int unsigned v, int unsigned ceiling);
		return (v > ceiling) ? ceiling : v;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(11, 30);
	endfunction

	function automatic logic signed [imm_pkg::VALUE_W-1:0] rand_value();
		case ($urandom_range(0, 7))
			0: return VALUE_MAX;
			1: return VALUE_MIN;
			2: return -1;
			3: return 0;
			4: return $signed($urandom_range(0, 15)) - 8;
			default: return $urandom();
		endcase
	endfunction

	// Mostly near the live range, with the first index past the edge included.
	function automatic logic [imm_pkg::INDEX_W-1:0] pick_index(int unsigned size);
		if ($urandom_range(0, 9) < 6)
			return imm_pkg::INDEX_W'($urandom_range(0, clamp(size, 255)));
		return imm_pkg::INDEX_W'($urandom_range(0, 255));
	endfunction

	// True when a compute at this position reads only elements that were loaded.
	function automatic bit dot_ready(int unsigned r, int unsigned c);
		if (r >= n_rows || c >= n_cols)
			return 1'b1;
		for (int unsigned k = 0; k < n_inner; k++)
			if (!a_loaded[r * MAX_INNER + k] || !b_loaded[k * MAX_COLS + c])
				return 1'b0;
		return 1'b1;
	endfunction

	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [imm_pkg::CFG_INDEX_W-1:0] idx,
			logic [imm_pkg::CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		case (idx)
			imm_pkg::REG_ROWS: rows_set = value[imm_pkg::ROWS_W-1:0];
			imm_pkg::REG_INNER: inner_set = value[imm_pkg::INNER_W-1:0];
			imm_pkg::REG_COLS: cols_set = value[imm_pkg::COLS_W-1:0];
			default: ;
		endcase
		n_rows = clamp(rows_set, MAX_ROWS);
		n_inner = clamp(inner_set, MAX_INNER);
		n_cols = clamp(cols_set, MAX_COLS);
	endtask

	task automatic set_sizes(int unsigned rows, int unsigned inner, int unsigned cols);
		wait_idle();
		write_reg(imm_pkg::REG_ROWS, imm_pkg::CFG_DATA_W'(rows));
		write_reg(imm_pkg::REG_INNER, imm_pkg::CFG_DATA_W'(inner));
		write_reg(imm_pkg::REG_COLS, imm_pkg::CFG_DATA_W'(cols));
		write_reg(REG_UNUSED, imm_pkg::CFG_DATA_W'($urandom_range(0, 511)));
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic send_item(logic [imm_pkg::ACTION_W-1:0] act,
			logic [imm_pkg::INDEX_W-1:0] row, logic [imm_pkg::INDEX_W-1:0] col,
			logic signed [imm_pkg::VALUE_W-1:0] value);
		int unsigned gap;
		gap = gapless ? 0 : pick_gap();
		if (gap != 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.action <= act;
		item_ch.row_index <= row;
		item_ch.col_index <= col;
		item_ch.element_value <= value;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		case (act)
			imm_pkg::ACT_LOAD_A: begin
				if (row < n_rows && col < n_inner)
					a_loaded[row * MAX_INNER + col] = 1'b1;
			end
			imm_pkg::ACT_LOAD_B: begin
				if (row < n_inner && col < n_cols)
					b_loaded[row * MAX_COLS + col] = 1'b1;
			end
			default: ;
		endcase
		accepted++;
	endtask

	task automatic noise_item();
		logic [imm_pkg::ACTION_W-1:0] act;
		logic [imm_pkg::INDEX_W-1:0]  row;
		logic [imm_pkg::INDEX_W-1:0]  col;
		act = imm_pkg::ACTION_W'($urandom_range(imm_pkg::ACT_LOAD_A, ACT_NONE));
		case (act)
			imm_pkg::ACT_LOAD_A: begin
				row = pick_index(n_rows);
				col = pick_index(n_inner);
			end
			imm_pkg::ACT_LOAD_B: begin
				row = pick_index(n_inner);
				col = pick_index(n_cols);
			end
			default: begin
				row = pick_index(n_rows);
				col = pick_index(n_cols);
				// A position with operands still missing is moved past the last row.
				if (act == imm_pkg::ACT_COMPUTE && !dot_ready(row, col))
					row = imm_pkg::INDEX_W'($urandom_range(n_rows, 255));
			end
		endcase
		send_item(act, row, col, rand_value());
	endtask

	// Loads the missing parts of one row of A and one column of B, refreshes a few
	// elements that already hold data, sometimes sends a noise item, then asks for the dot product.
	task automatic run_dot(int unsigned r, int unsigned c);
		for (int unsigned k = 0; k < n_inner; k++)
			if (!a_loaded[r * MAX_INNER + k] || $urandom_range(0, 7) == 0)
				send_item(imm_pkg::ACT_LOAD_A, imm_pkg::INDEX_W'(r), imm_pkg::INDEX_W'(k),
					rand_value());
		for (int unsigned k = 0; k < n_inner; k++)
			if (!b_loaded[k * MAX_COLS + c] || $urandom_range(0, 7) == 0)
				send_item(imm_pkg::ACT_LOAD_B, imm_pkg::INDEX_W'(k), imm_pkg::INDEX_W'(c),
					rand_value());
		if ($urandom_range(0, 9) == 0)
			noise_item();
		send_item(imm_pkg::ACT_COMPUTE, imm_pkg::INDEX_W'(r), imm_pkg::INDEX_W'(c),
			rand_value());
	endtask

	task automatic random_phase(int unsigned budget);
		int unsigned first;
		first = accepted;
		gapless = ($urandom_range(0, 3) == 0);
		while (accepted - first < budget) begin
			if (n_rows == 0 || n_inner == 0 || n_cols == 0 || $urandom_range(0, 9) < 3)
				noise_item();
			else
				run_dot($urandom_range(0, n_rows - 1), $urandom_range(0, n_cols - 1));
		end
		gapless = 1'b0;
	endtask

	task automatic directed_items();
		set_sizes(4, 3, 5);
		// Nothing is loaded yet, so only positions outside the sizes are asked for.
		send_item(imm_pkg::ACT_COMPUTE, 8'd255, 8'd255, 0);
		send_item(imm_pkg::ACT_COMPUTE, 8'd4, 8'd0, 0);
		send_item(imm_pkg::ACT_COMPUTE, 8'd0, 8'd5, VALUE_MAX);
		send_item(ACT_NONE, 8'd1, 8'd1, VALUE_MAX);
		// Loads just past each edge are dropped.
		send_item(imm_pkg::ACT_LOAD_A, 8'd4, 8'd0, -1);
		send_item(imm_pkg::ACT_LOAD_A, 8'd0, 8'd3, -1);
		send_item(imm_pkg::ACT_LOAD_B, 8'd3, 8'd0, -1);
		send_item(imm_pkg::ACT_LOAD_B, 8'd0, 8'd5, -1);
		send_item(imm_pkg::ACT_LOAD_B, 8'd255, 8'd255, -1);
		// Largest magnitudes in the last row and column make the sum wrap.
		send_item(imm_pkg::ACT_LOAD_A, 8'd3, 8'd0, VALUE_MAX);
		send_item(imm_pkg::ACT_LOAD_A, 8'd3, 8'd1, VALUE_MIN);
		send_item(imm_pkg::ACT_LOAD_A, 8'd3, 8'd2, -1);
		send_item(imm_pkg::ACT_LOAD_B, 8'd0, 8'd4, VALUE_MAX);
		send_item(imm_pkg::ACT_LOAD_B, 8'd1, 8'd4, VALUE_MIN);
		send_item(imm_pkg::ACT_LOAD_B, 8'd2, 8'd4, -1);
		send_item(imm_pkg::ACT_COMPUTE, 8'd3, 8'd4, 0);
		send_item(imm_pkg::ACT_LOAD_A, 8'd0, 8'd0, 0);
		send_item(imm_pkg::ACT_LOAD_A, 8'd0, 8'd1, 1);
		send_item(imm_pkg::ACT_LOAD_A, 8'd0, 8'd2, -1);
		send_item(imm_pkg::ACT_LOAD_B, 8'd0, 8'd0, 1);
		send_item(imm_pkg::ACT_LOAD_B, 8'd1, 8'd0, 1);
		send_item(imm_pkg::ACT_LOAD_B, 8'd2, 8'd0, 1);
		send_item(imm_pkg::ACT_COMPUTE, 8'd0, 8'd0, 0);
		send_item(imm_pkg::ACT_COMPUTE, 8'd0, 8'd4, 0);
	endtask

	// Receiver: short stalls, occasional long ones and stretches without any.
	initial begin : result_taker
		int unsigned run_left;
		bit          run_ready;
		result_ch.ready <= 1'b0;
		run_left = 0;
		run_ready = 1'b1;
		forever begin
			@(posedge clk);
			if (run_left == 0) begin
				case ($urandom_range(0, 9))
					0: begin
						run_ready = 1'b1;
						run_left = $urandom_range(20, 150);
					end
					1, 2, 3, 4: begin
						run_ready = 1'b0;
						run_left = pick_gap();
					end
					default: begin
						run_ready = 1'b1;
						run_left = 1;
					end
				endcase
				if (run_left == 0) begin
					run_ready = 1'b1;
					run_left = 1;
				end
			end
			run_left--;
			result_ch.ready <= run_ready && !long_hold;
		end
	end

	// One long hold on the result side while items keep coming, so that the
	// output register fills and the block stops taking items.
	initial begin : result_hold
		int unsigned held;
		long_hold <= 1'b0;
		wait (hold_armed);
		@(posedge clk);
		long_hold <= 1'b1;
		held = 0;
		while (held < HOLD_CYCLES) begin
			@(posedge clk);
			held++;
		end
		long_hold <= 1'b0;
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("integer_matrix_multiply_core: mismatch");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.action <= imm_pkg::ACT_LOAD_A;
		item_ch.row_index <= '0;
		item_ch.col_index <= '0;
		item_ch.element_value <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= imm_pkg::REG_ROWS;
		cfg_ch.data <= '0;
		hold_armed = 1'b0;
		gapless = 1'b0;
		accepted = 0;
		rows_set = imm_pkg::ROWS_RESET;
		inner_set = imm_pkg::INNER_RESET;
		cols_set = imm_pkg::COLS_RESET;
		n_rows = clamp(rows_set, MAX_ROWS);
		n_inner = clamp(inner_set, MAX_INNER);
		n_cols = clamp(cols_set, MAX_COLS);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_items();
		set_sizes(1, 1, 1);
		random_phase(60);
		// Sizes above capacity saturate; this phase runs full-length dot products.
		set_sizes(63, 300, 40);
		random_phase(500);
		set_sizes(0, 511, 63);
		random_phase(40);
		set_sizes(8, 0, 8);
		random_phase(40);
		set_sizes(32, 8, 0);
		random_phase(30);
		set_sizes(5, 16, 7);
		random_phase(80);
		wait_idle();
		random_phase(80);
		set_sizes(32, 4, 32);
		hold_armed = 1'b1;
		random_phase(150);
		set_sizes(3, 64, 2);
		random_phase(80);
		set_sizes(16, 2, 63);
		random_phase(80);
		wait_idle();

		if (mismatches == 0 && outstanding == 0)
			$display("integer_matrix_multiply_core: match");
		else
			$display("integer_matrix_multiply_core: mismatch");
		$finish;
	end

endmodule
